// File: design/spq_pkg.sv
package spq_pkg;

  // Width of one stored entry and of the value fields.
  localparam int DATA_W = 32;

  // Default number of cells in the row.
  localparam int DEFAULT_CAPACITY = 16;

  // Width of the entry_count result field.
  localparam int COUNT_OUT_W = 5;

  // Operation codes carried by an input transfer.
  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_CLR = 2'd2
  } op_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic enq;
    logic deq;
    logic clr;
    logic max_first;
  } cell_ctrl_t;

endpackage

// File: design/spq_cell.sv
module spq_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spq_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [spq_pkg::DATA_W-1:0]   new_value,
  input  logic signed [spq_pkg::DATA_W-1:0]   left_value,
  input  logic                                left_valid,
  input  logic signed [spq_pkg::DATA_W-1:0]   right_value,
  input  logic                                right_valid,
  input  logic                                taken_in,
  output logic                                taken_out,
  output logic signed [spq_pkg::DATA_W-1:0]   value,
  output logic                                valid
);

  logic signed [spq_pkg::DATA_W-1:0] value_r;
  logic signed [spq_pkg::DATA_W-1:0] value_nxt;
  logic                              valid_r;
  logic                              valid_nxt;
  logic                              goes_before;
  logic                              claim;

  // The new value belongs in front of this entry when the entry would be
  // served after it. An empty cell also claims the value, which puts it at
  // the tail when no held entry ranks below it.
  assign goes_before = valid_r &&
                       (ctrl.max_first ? (value_r < new_value) : (value_r > new_value));
  assign claim       = goes_before || !valid_r;
  assign taken_out   = taken_in || claim;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    priority if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.deq) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (ctrl.enq) begin
      priority if (taken_in) begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end else if (claim) begin
        value_nxt = new_value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

// File: design/sorted_priority_queue.sv
// Latency: the result of an input transfer is offered on the result channel
// in the cycle after the transfer, straight from the updated cells.
// Throughput: one item per cycle while the result channel is not stalled;
// every cell decides its next entry in the same cycle.
// Reset (rst_n low at a clock edge): the queue is empty, no result is pending
// and max_first returns to 1. Stored values are left as they are.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration port.
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_opcode,
  input  logic signed [spq_pkg::DATA_W-1:0]   in_value,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [spq_pkg::DATA_W-1:0]   out_front_value,
  output logic                                out_is_empty,
  output logic [spq_pkg::COUNT_OUT_W-1:0]     out_entry_count,
  output logic                                out_rejected
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // The row of cells holds the queue in service order: cell 0 is the front.
  // Valid cells always form an unbroken run starting at cell 0.
  logic signed [spq_pkg::DATA_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]               cell_valid;
  logic [CAPACITY:0]                 taken;

  logic                 max_first_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 rej_r;
  logic                 rej_nxt;
  logic                 out_valid_r;
  logic                 in_accept;
  logic                 full;
  logic                 empty;
  spq_pkg::op_t         op;
  spq_pkg::cell_ctrl_t  ctrl;

  // A new transfer is taken whenever the result slot is free or is being
  // emptied in the same cycle. The result fields are read directly from the
  // cells, which only change on an accepted transfer, so a pending result
  // holds steady while it waits.
  assign in_accept = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign full      = cell_valid[CAPACITY-1];
  assign empty     = !cell_valid[0];
  assign op        = spq_pkg::op_t'(in_opcode);

  // Decode the operation into one command for the whole row. A rejected
  // operation and the unused opcode leave the row untouched.
  always_comb begin
    ctrl           = '0;
    ctrl.max_first = max_first_r;
    count_nxt      = count_r;
    rej_nxt        = rej_r;
    if (in_accept) begin
      rej_nxt = 1'b0;
      unique case (op)
        spq_pkg::OP_ENQ: begin
          if (full) begin
            rej_nxt = 1'b1;
          end else begin
            ctrl.enq  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        spq_pkg::OP_DEQ: begin
          if (empty) begin
            rej_nxt = 1'b1;
          end else begin
            ctrl.deq  = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        spq_pkg::OP_CLR: begin
          ctrl.clr  = 1'b1;
          count_nxt = '0;
        end
        default: begin
          rej_nxt = 1'b0;
        end
      endcase
    end
  end

  // The insert position ripples down the row: once a cell has claimed the
  // new value, every cell after it takes its left neighbor's entry.
  assign taken[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [spq_pkg::DATA_W-1:0] left_value;
    logic                              left_valid;
    logic signed [spq_pkg::DATA_W-1:0] right_value;
    logic                              right_valid;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_valid = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_value   (in_value),
      .left_value  (left_value),
      .left_valid  (left_valid),
      .right_value (right_value),
      .right_valid (right_valid),
      .taken_in    (taken[i]),
      .taken_out   (taken[i+1]),
      .value       (cell_value[i]),
      .valid       (cell_valid[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_first_r <= 1'b1;
      count_r     <= '0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_first_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      rej_r   <= rej_nxt;
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result fields: the front entry, or zero when nothing is held.
  assign out_valid       = out_valid_r;
  assign out_front_value = cell_valid[0] ? cell_value[0] : '0;
  assign out_is_empty    = !cell_valid[0];
  assign out_entry_count = spq_pkg::COUNT_OUT_W'(count_r);
  assign out_rejected    = rej_r;

  // The valid cells must stay a solid run from the front of the row.
  a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + CAPACITY'(1))) == '0)
    else $error("valid cells are not contiguous from the front");

  // The entry counter must agree with the number of valid cells.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("entry counter disagrees with the valid cells");

  // An enqueue that finds room grows the queue by exactly one entry.
  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && op == spq_pkg::OP_ENQ && !full) |=>
      (count_r == $past(count_r) + CNT_W'(1)) && !rej_r)
    else $error("accepted enqueue did not add one entry");

  // A dequeue on an empty queue is flagged and changes nothing.
  a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && op == spq_pkg::OP_DEQ && empty) |=>
      rej_r && count_r == '0 && !cell_valid[0])
    else $error("dequeue while empty was not rejected cleanly");

endmodule
